FILE: src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/fbpa_pkg.sv
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 256;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 16;
    localparam int TOTAL_W   = 9;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 3;
    localparam int IDX_OUT_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH   = 2;
    localparam int DIV_W     = 32;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STAT_W-1:0] ST_ALIGN = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

    localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd64;
    localparam logic [TOTAL_W-1:0] TOTAL_RST = 9'd256;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              below;
        logic [ADDR_W-1:0] offset;
    } t_job;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ADDR_W-1:0]    block_address;
        logic [IDX_OUT_W-1:0] block_index;
        logic [TOTAL_W-1:0]   free_blocks;
    } t_result;

endpackage

FILE: src/fbpa_queue.sv
module fbpa_queue
    import fbpa_pkg::*;
#(
    parameter int W     = 1,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/fbpa_front.sv
module fbpa_front
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [ADDR_W-1:0] i_base,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_job              o_job
);

    logic r_valid;
    t_job r_job;
    logic w_take;

    assign o_full   = r_valid && i_q_full;
    assign w_take   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_job    = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    // classify: offset from base and below-base flag
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job.action <= i_action;
            r_job.below  <= (i_address < i_base);
            r_job.offset <= i_address - i_base;
        end
    end

endmodule

FILE: src/fbpa_div.sv
module fbpa_div
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quot,
    output logic [SIZE_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_quot;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_dvsr;
    logic [SIZE_W:0]   w_sh;
    logic [SIZE_W:0]   w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_quot[DIV_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvsr});
    assign w_diff = w_sh - {1'b0, r_dvsr};
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(DIV_W - 1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[SIZE_W-1:0] : w_sh[SIZE_W-1:0];
        end
    end

endmodule

FILE: src/fbpa_back.sv
`include "assert_macros.svh"

module fbpa_back
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ADDR_W-1:0]  i_base,
    input  logic [SIZE_W-1:0]  i_block_size,
    input  logic [TOTAL_W-1:0] i_block_total,
    input  logic               i_q_empty,
    input  t_job               i_job,
    output logic               o_q_pop,
    input  logic               i_out_full,
    output logic               o_out_push,
    output t_result            o_result
);

    localparam int IW     = $clog2(MAX_BLOCKS);
    localparam int CW     = $clog2(MAX_BLOCKS + 1);
    localparam int EXT_W  = CW + SIZE_W;
    localparam int CMP_W  = (EXT_W > ADDR_W) ? EXT_W : ADDR_W;
    localparam int PROD_W = IW + SIZE_W;
    localparam int INIT_TOTAL = (MAX_BLOCKS < int'(TOTAL_RST)) ? MAX_BLOCKS : int'(TOTAL_RST);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        r_state;
    logic [CW-1:0]     r_top;
    logic [CW-1:0]     r_min;
    logic [CW-1:0]     r_total;
    logic [EXT_W-1:0]  r_extent;
    logic [ACT_W-1:0]  r_act;
    logic              r_below;
    logic [ADDR_W-1:0] r_off;
    logic [IW-1:0]     r_fill_val;
    logic              r_use_fill;
    logic [IW-1:0]     r_idx;
    logic [PROD_W-1:0] r_prod;
    t_result           r_res;
    logic [IW-1:0]     r_stack [MAX_BLOCKS];
    logic [IW-1:0]     r_rd_data;

    logic              w_range_bad;
    logic              w_div_start;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_quot;
    logic [SIZE_W-1:0] w_rem;
    logic [IW-1:0]     w_quot_idx;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_idx;
    logic [IW-1:0]     w_rd_idx;
    logic [CW-1:0]     w_sat;
    t_result           w_chk_res;

    always_comb begin
        if (i_block_total == '0) begin
            w_sat = CW'(1);
        end else if (32'(i_block_total) > 32'(MAX_BLOCKS)) begin
            w_sat = CW'(MAX_BLOCKS);
        end else begin
            w_sat = CW'(i_block_total);
        end
    end

    assign w_range_bad = r_below || (CMP_W'(r_off) >= CMP_W'(r_extent));
    assign w_div_start = (r_state == S_CHECK) && (r_act == ACT_FREE) && !w_range_bad;
    assign w_quot_idx  = w_quot[IW-1:0];
    assign w_wr_en     = (r_state == S_DIV) && w_div_done && (w_rem == '0)
                         && (r_top < r_total);
    assign w_wr_idx    = r_top[IW-1:0];
    assign w_rd_idx    = IW'(r_top - CW'(1));
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_out_push  = (r_state == S_DONE) && !i_out_full;

    always_comb begin
        w_chk_res = '0;
        if (r_act == ACT_ALLOC && r_top == '0) begin
            w_chk_res.status = ST_EMPTY;
        end else if (r_act == ACT_FREE && w_range_bad) begin
            w_chk_res.status = ST_RANGE;
        end else begin
            w_chk_res.status = ST_OK;
        end
    end

    always_comb begin
        o_result             = r_res;
        o_result.free_blocks = TOTAL_W'(r_top);
    end

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_off),
        .i_divisor  (i_block_size),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_wr_idx] <= w_quot_idx;
        end
        r_rd_data <= r_stack[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= CW'(INIT_TOTAL);
            r_min   <= CW'(INIT_TOTAL);
            r_total <= CW'(INIT_TOTAL);
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    case (r_act)
                        ACT_ALLOC: begin
                            if (r_top == '0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_top <= r_top - CW'(1);
                                if (r_top == r_min) begin
                                    r_min <= r_top - CW'(1);
                                end
                                r_state <= S_READ;
                            end
                        end
                        ACT_FREE: begin
                            r_state <= w_range_bad ? S_DONE : S_DIV;
                        end
                        ACT_CLEAR: begin
                            r_total <= w_sat;
                            r_top   <= w_sat;
                            r_min   <= w_sat;
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_READ: r_state <= S_MUL;
                S_MUL:  r_state <= S_ADD;
                S_ADD:  r_state <= S_DONE;
                S_DIV: begin
                    if (w_div_done) begin
                        if (w_wr_en) begin
                            r_top <= r_top + CW'(1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_extent <= {{SIZE_W{1'b0}}, r_total} * {{CW{1'b0}}, i_block_size};
        case (r_state)
            S_IDLE: begin
                r_act   <= i_job.action;
                r_below <= i_job.below;
                r_off   <= i_job.offset;
            end
            S_CHECK: begin
                // entries below the low-water mark still hold their refill value
                r_fill_val <= IW'(r_total - r_top);
                r_use_fill <= (r_top == r_min);
                r_res      <= w_chk_res;
            end
            S_READ: begin
                r_idx <= r_use_fill ? r_fill_val : r_rd_data;
            end
            S_MUL: begin
                r_prod <= {{SIZE_W{1'b0}}, r_idx} * {{IW{1'b0}}, i_block_size};
            end
            S_ADD: begin
                r_res.block_address <= i_base + ADDR_W'(r_prod);
                r_res.block_index   <= IDX_OUT_W'(r_idx);
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_rem != '0) begin
                        r_res.status <= ST_ALIGN;
                    end else begin
                        r_res.block_index <= IDX_OUT_W'(w_quot_idx);
                        if (r_top >= r_total) begin
                            r_res.status <= ST_FULL;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    `ASSERT_IMPLY(a_top_within_total, i_clk, i_rst_n, 1'b1, r_top <= r_total)
    `ASSERT_IMPLY(a_mark_below_top, i_clk, i_rst_n, 1'b1, r_min <= r_top)
    `ASSERT_IMPLY(a_div_done_waited, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    `ASSERT_IMPLY(a_rem_bounded, i_clk, i_rst_n, w_div_done, w_rem < i_block_size)
    `ASSERT_NEXT(a_push_then_idle, i_clk, i_rst_n, o_out_push, r_state == S_IDLE)

endmodule

FILE: src/fixed_block_pool_allocator_unit.sv
// The executing stage holds one item at a time and takes the next only after the last result is
// pushed; a free inside the pool runs through the 32-step shift-subtract divider.
// A two-deep queue sits between the classifying stage and the executing stage, and after it.
// Reset (synchronous, active low) clears control state; the free stack needs no clearing pass,
// its refill values are supplied from a low-water mark.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [ADDR_W-1:0]    i_address,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [STAT_W-1:0]    o_status,
    output logic [ADDR_W-1:0]    o_block_address,
    output logic [IDX_OUT_W-1:0] o_block_index,
    output logic [TOTAL_W-1:0]   o_free_blocks,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    logic [ADDR_W-1:0]  r_base;
    logic [SIZE_W-1:0]  r_size;
    logic [TOTAL_W-1:0] r_total;

    logic    w_jq_push;
    logic    w_jq_full;
    logic    w_jq_pop;
    logic    w_jq_empty;
    t_job    w_job_in;
    t_job    w_job_out;
    logic    w_rq_push;
    logic    w_rq_full;
    t_result w_res_in;
    t_result w_res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RST;
            r_size  <= SIZE_RST;
            r_total <= TOTAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE:  r_base  <= i_cfg_data;
                REG_SIZE:  r_size  <= i_cfg_data[SIZE_W-1:0];
                REG_TOTAL: r_total <= i_cfg_data[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fbpa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .o_full    (o_full),
        .i_action  (i_action),
        .i_address (i_address),
        .i_base    (r_base),
        .i_q_full  (w_jq_full),
        .o_q_push  (w_jq_push),
        .o_job     (w_job_in)
    );

    fbpa_queue #(
        .W     ($bits(t_job)),
        .DEPTH (Q_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_jq_push),
        .i_data  (w_job_in),
        .o_full  (w_jq_full),
        .i_pop   (w_jq_pop),
        .o_data  (w_job_out),
        .o_empty (w_jq_empty)
    );

    fbpa_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_base        (r_base),
        .i_block_size  (r_size),
        .i_block_total (r_total),
        .i_q_empty     (w_jq_empty),
        .i_job         (w_job_out),
        .o_q_pop       (w_jq_pop),
        .i_out_full    (w_rq_full),
        .o_out_push    (w_rq_push),
        .o_result      (w_res_in)
    );

    fbpa_queue #(
        .W     ($bits(t_result)),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rq_push),
        .i_data  (w_res_in),
        .o_full  (w_rq_full),
        .i_pop   (i_pop),
        .o_data  (w_res_out),
        .o_empty (o_empty)
    );

    assign o_status        = w_res_out.status;
    assign o_block_address = w_res_out.block_address;
    assign o_block_index   = w_res_out.block_index;
    assign o_free_blocks   = w_res_out.free_blocks;

endmodule
